// ----- rtl/sap_pkg.sv -----
`timescale 1ns / 1ps

package sap_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // d < -(1 - 0.001) in Q30
    localparam logic signed [33:0] OPP_LIMIT = -34'sd1072668082;
    // 0.01 in Q60
    localparam logic [63:0] SMALL_AXIS = 64'd11529215046068470;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_OPPOSITE = 2'd1,
        ST_ZERO     = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic [31:0]        l2a;
        logic [31:0]        l2b;
        logic               zero;
    } t_req;

endpackage

// ----- rtl/sap_isqrt.sv -----
`timescale 1ns / 1ps

module sap_isqrt #(
    parameter int RW = 64
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RW-1:0]   i_rad,
    output logic [RW/2-1:0] o_root
);

    localparam int W = RW / 2;

    logic [W+1:0]  r_rem  [W];
    logic [W-1:0]  r_root [W];
    logic [RW-1:0] r_rad  [W];

    // one result bit per stage
    function automatic logic [W+2+W+RW-1:0] sq_step(input logic [W+1:0] rem,
                                                    input logic [W-1:0] root,
                                                    input logic [RW-1:0] rad);
        logic [W+1:0] t;
        logic [W+1:0] trial;
        logic [W+1:0] rem_n;
        logic [W-1:0] root_n;
        t     = {rem[W-1:0], rad[RW-1:RW-2]};
        trial = {root, 2'b01};
        if (t >= trial) begin
            rem_n  = t - trial;
            root_n = {root[W-2:0], 1'b1};
        end else begin
            rem_n  = t;
            root_n = {root[W-2:0], 1'b0};
        end
        return {rem_n, root_n, rad << 2};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_rem[0], r_root[0], r_rad[0]} <= sq_step('0, '0, i_rad);
            for (int k = 1; k < W; k++) begin
                {r_rem[k], r_root[k], r_rad[k]} <= sq_step(r_rem[k-1], r_root[k-1], r_rad[k-1]);
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule

// ----- rtl/sap_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. The quotient must fit in QW bits.
module sap_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lq  [QW];
    logic [DW-1:0] r_den [QW];

    function automatic logic [DW+QW-1:0] dv_step(input logic [DW-1:0] rem,
                                                 input logic [QW-1:0] lq,
                                                 input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] diff;
        t    = {rem, lq[QW-1]};
        diff = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            return {diff[DW-1:0], lq[QW-2:0], 1'b1};
        end else begin
            return {t[DW-1:0], lq[QW-2:0], 1'b0};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_rem[0], r_lq[0]} <= dv_step(DW'(i_num >> QW), i_num[QW-1:0], i_den);
            r_den[0] <= i_den;
            for (int k = 1; k < QW; k++) begin
                {r_rem[k], r_lq[k]} <= dv_step(r_rem[k-1], r_lq[k-1], r_den[k-1]);
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_lq[QW-1];

endmodule

// ----- rtl/sap_front.sv -----
`timescale 1ns / 1ps

module sap_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_from_x,
    input  logic signed [15:0] i_from_y,
    input  logic signed [15:0] i_from_z,
    input  logic signed [15:0] i_to_x,
    input  logic signed [15:0] i_to_y,
    input  logic signed [15:0] i_to_z,
    input  logic               i_q_full,
    output logic               o_push,
    output sap_pkg::t_req      o_req
);

    logic               r_fv;
    sap_pkg::t_req      r_req;
    sap_pkg::t_req      n_req;
    logic signed [31:0] sqa [3];
    logic signed [31:0] sqb [3];
    logic               accept;

    assign o_stall = r_fv && i_q_full;
    assign o_push  = r_fv && !i_q_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        sqa[0] = i_from_x * i_from_x;
        sqa[1] = i_from_y * i_from_y;
        sqa[2] = i_from_z * i_from_z;
        sqb[0] = i_to_x * i_to_x;
        sqb[1] = i_to_y * i_to_y;
        sqb[2] = i_to_z * i_to_z;
        n_req.ax   = i_from_x;
        n_req.ay   = i_from_y;
        n_req.az   = i_from_z;
        n_req.bx   = i_to_x;
        n_req.by   = i_to_y;
        n_req.bz   = i_to_z;
        n_req.l2a  = $unsigned(sqa[0]) + $unsigned(sqa[1]) + $unsigned(sqa[2]);
        n_req.l2b  = $unsigned(sqb[0]) + $unsigned(sqb[1]) + $unsigned(sqb[2]);
        // a zero-length vector skips nothing downstream, it only forces the result
        n_req.zero = (n_req.l2a == 32'd0) || (n_req.l2b == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

// ----- rtl/sap_queue.sv -----
`timescale 1ns / 1ps

module sap_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sap_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output sap_pkg::t_req o_req
);

    sap_pkg::t_req                r_mem [sap_pkg::QDEPTH];
    logic [sap_pkg::QPTR_W-1:0]   r_wr;
    logic [sap_pkg::QPTR_W-1:0]   r_rd;
    logic [sap_pkg::QPTR_W:0]     r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == (sap_pkg::QPTR_W + 1)'(sap_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;
    assign o_req   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + sap_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + sap_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (sap_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (sap_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

// ----- rtl/sap_back.sv -----
`timescale 1ns / 1ps

module sap_back #(
    parameter int OUT_FRAC_BITS = sap_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  sap_pkg::t_req      i_req,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic [1:0]         o_status
);

    localparam int F          = OUT_FRAC_BITS;
    localparam int RADW       = 64;
    localparam int LS         = RADW / 2;
    localparam int DW         = 32;
    localparam int NORM_SHIFT = 46;
    localparam int NW1        = 16 + NORM_SHIFT;
    localparam int QW1        = 31;
    localparam int NW2        = F + 33;
    localparam int QW2        = F + 2;
    localparam int RND_W      = 1 << (30 - F);
    localparam int TOT        = 2 * LS + QW1 + QW2 + 6;

    typedef struct packed {
        logic [5:0][15:0] comp;
        logic             zero;
    } t_d1;

    typedef struct packed {
        logic [5:0] neg;
        logic       zero;
    } t_d2;

    typedef struct packed {
        logic [2:0][33:0] num;
        logic             opp;
        logic             zero;
    } t_d3;

    typedef struct packed {
        logic [2:0]  neg;
        logic [32:0] w;
        logic        dz;
        logic        opp;
        logic        zero;
    } t_d4;

    logic               en;
    logic [TOT-1:0]     r_v;
    sap_pkg::t_req      r_s0;

    logic [LS-1:0]      len_a;
    logic [LS-1:0]      len_b;
    t_d1                r_d1 [LS];
    t_d1                n_d1;
    logic [QW1-1:0]     q1 [6];
    t_d2                r_d2 [QW1];
    t_d2                n_d2;

    logic signed [31:0] r_u [6];
    logic               r_z2;
    logic signed [63:0] r_pd [3];
    logic signed [63:0] r_pc [6];
    logic signed [63:0] r_ps [3];
    logic signed [31:0] r_ua3 [3];
    logic               r_z3;
    logic signed [63:0] r_dot;
    logic signed [63:0] r_cr [3];
    logic [63:0]        r_xy;
    logic [63:0]        r_yz;
    logic signed [31:0] r_ua4 [3];
    logic               r_z4;
    logic signed [33:0] r_d;
    logic signed [33:0] r_c [3];
    logic signed [33:0] r_e [3];
    logic [63:0]        r_l2e;
    logic               r_z5;
    logic               xy_small;

    logic               opp;
    logic signed [35:0] vs;
    logic [34:0]        vc;
    logic [RADW-1:0]    rad_c;
    t_d3                r_d3 [LS];
    t_d3                n_d3;
    logic [LS-1:0]      root_c;

    logic [NW2-1:0]     num2 [3];
    t_d4                r_d4 [QW2];
    t_d4                n_d4;
    logic [QW2-1:0]     q2 [3];

    logic [15:0]        r_qw;
    logic [15:0]        r_qx;
    logic [15:0]        r_qy;
    logic [15:0]        r_qz;
    sap_pkg::t_status   r_st;
    logic [15:0]        n_qw;
    logic [15:0]        n_qx;
    logic [15:0]        n_qy;
    logic [15:0]        n_qz;
    sap_pkg::t_status   n_st;

    // round half away from zero, divide by 2^30
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] n);
        logic [63:0] m;
        logic [33:0] q;
        m = n[63] ? -n : n;
        q = 34'((m + 64'd536870912) >> 30);
        return n[63] ? -q : q;
    endfunction

    function automatic logic [15:0] sat(input logic signed [63:0] v);
        logic signed [63:0] lim;
        logic signed [63:0] t;
        lim = 64'sd1 <<< F;
        t   = v;
        if (t > lim) begin
            t = lim;
        end
        if (t < -lim) begin
            t = -lim;
        end
        if (t > 64'sd32767) begin
            t = 64'sd32767;
        end
        if (t < -64'sd32768) begin
            t = -64'sd32768;
        end
        return t[15:0];
    endfunction

    // advance the whole pipeline unless a finished result is held
    assign en    = !(r_v[TOT-1] && i_stall);
    assign o_pop = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[TOT-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_req;
        end
    end

    // vector lengths scaled by 2^16
    sap_isqrt #(.RW(RADW)) u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({r_s0.l2a, 32'd0}),
        .o_root (len_a)
    );

    sap_isqrt #(.RW(RADW)) u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({r_s0.l2b, 32'd0}),
        .o_root (len_b)
    );

    always_comb begin
        n_d1.comp[0] = r_s0.ax;
        n_d1.comp[1] = r_s0.ay;
        n_d1.comp[2] = r_s0.az;
        n_d1.comp[3] = r_s0.bx;
        n_d1.comp[4] = r_s0.by;
        n_d1.comp[5] = r_s0.bz;
        n_d1.zero    = r_s0.zero;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= n_d1;
            for (int k = 1; k < LS; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_norm
        logic signed [15:0] cv;
        logic [15:0]        mag;
        logic [DW-1:0]      len;
        assign cv  = $signed(r_d1[LS-1].comp[g]);
        assign mag = cv[15] ? -cv : cv;
        assign len = (g < 3) ? len_a : len_b;
        sap_div #(.NW(NW1), .DW(DW), .QW(QW1)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ((NW1'(mag) << NORM_SHIFT) + NW1'(len >> 1)),
            .i_den (len),
            .o_quo (q1[g])
        );
        assign n_d2.neg[g] = cv[15];
    end

    assign n_d2.zero = r_d1[LS-1].zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= n_d2;
            for (int k = 1; k < QW1; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // unit vectors, products, sums, rounding
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r_u[k] <= r_d2[QW1-1].neg[k] ? -$signed({1'b0, q1[k]}) : $signed({1'b0, q1[k]});
            end
            r_z2 <= r_d2[QW1-1].zero;

            for (int k = 0; k < 3; k++) begin
                r_pd[k]  <= r_u[k] * r_u[k+3];
                r_ps[k]  <= r_u[k] * r_u[k];
                r_ua3[k] <= r_u[k];
            end
            r_pc[0] <= r_u[1] * r_u[5];
            r_pc[1] <= r_u[2] * r_u[4];
            r_pc[2] <= r_u[2] * r_u[3];
            r_pc[3] <= r_u[0] * r_u[5];
            r_pc[4] <= r_u[0] * r_u[4];
            r_pc[5] <= r_u[1] * r_u[3];
            r_z3    <= r_z2;

            r_dot   <= r_pd[0] + r_pd[1] + r_pd[2];
            r_cr[0] <= r_pc[0] - r_pc[1];
            r_cr[1] <= r_pc[2] - r_pc[3];
            r_cr[2] <= r_pc[4] - r_pc[5];
            r_xy    <= $unsigned(r_ps[0]) + $unsigned(r_ps[1]);
            r_yz    <= $unsigned(r_ps[1]) + $unsigned(r_ps[2]);
            for (int k = 0; k < 3; k++) begin
                r_ua4[k] <= r_ua3[k];
            end
            r_z4    <= r_z3;

            r_d <= rnd30(r_dot);
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= rnd30(r_cr[k]);
            end
            // fall back to the x axis when a lies close to z
            if (xy_small) begin
                r_e[0] <= '0;
                r_e[1] <= -34'(r_ua4[2]);
                r_e[2] <= 34'(r_ua4[1]);
                r_l2e  <= r_yz;
            end else begin
                r_e[0] <= -34'(r_ua4[1]);
                r_e[1] <= 34'(r_ua4[0]);
                r_e[2] <= '0;
                r_l2e  <= r_xy;
            end
            r_z5 <= r_z4;
        end
    end

    assign xy_small = r_xy < sap_pkg::SMALL_AXIS;

    always_comb begin
        opp   = r_d < sap_pkg::OPP_LIMIT;
        vs    = (36'sd1 <<< 31) + (36'(r_d) <<< 1);
        vc    = vs[35] ? '0 : vs[34:0];
        rad_c = opp ? r_l2e : (RADW'(vc) << 30);
        for (int k = 0; k < 3; k++) begin
            n_d3.num[k] = opp ? r_e[k] : r_c[k];
        end
        n_d3.opp  = opp;
        n_d3.zero = r_z5;
    end

    // half-angle term, or the fallback axis length
    sap_isqrt #(.RW(RADW)) u_sqrt_c (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad_c),
        .o_root (root_c)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= n_d3;
            for (int k = 1; k < LS; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [33:0] ns;
        logic [33:0]        mag;
        assign ns       = $signed(r_d3[LS-1].num[g]);
        assign mag      = ns[33] ? -ns : ns;
        assign num2[g]  = (NW2'(mag) << F) + NW2'(root_c >> 1);
        assign n_d4.neg[g] = ns[33];
        sap_div #(.NW(NW2), .DW(DW), .QW(QW2)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num2[g]),
            .i_den (root_c),
            .o_quo (q2[g])
        );
    end

    always_comb begin
        n_d4.w    = r_d3[LS-1].opp ? '0 : ((33'(root_c) + 33'(RND_W)) >> (31 - F));
        n_d4.dz   = (root_c == '0);
        n_d4.opp  = r_d3[LS-1].opp;
        n_d4.zero = r_d3[LS-1].zero;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d4[0] <= n_d4;
            for (int k = 1; k < QW2; k++) begin
                r_d4[k] <= r_d4[k-1];
            end
        end
    end

    always_comb begin
        logic signed [63:0] qv [3];
        for (int k = 0; k < 3; k++) begin
            qv[k] = r_d4[QW2-1].neg[k] ? -$signed(64'(q2[k])) : $signed(64'(q2[k]));
        end
        n_qw = sat($signed(64'(r_d4[QW2-1].w)));
        n_qx = r_d4[QW2-1].dz ? '0 : sat(qv[0]);
        n_qy = r_d4[QW2-1].dz ? '0 : sat(qv[1]);
        n_qz = r_d4[QW2-1].dz ? '0 : sat(qv[2]);
        n_st = r_d4[QW2-1].opp ? sap_pkg::ST_OPPOSITE : sap_pkg::ST_NORMAL;
        if (r_d4[QW2-1].zero) begin
            n_qw = '0;
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
            n_st = sap_pkg::ST_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw <= n_qw;
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_st <= n_st;
        end
    end

    assign o_valid  = r_v[TOT-1];
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_status = r_st;

`ifndef NO_ASSERTIONS
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sap_pkg::ST_ZERO) |->
            (o_quat_w == '0 && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0))
        else $error("zero-length result carries a nonzero quaternion");

    a_opp_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sap_pkg::ST_OPPOSITE) |-> (o_quat_w == '0))
        else $error("fallback result has nonzero w");

    a_norm_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sap_pkg::ST_NORMAL) |-> !o_quat_w[15])
        else $error("normal result has negative w");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (r_v == $past(r_v)))
        else $error("pipeline moved while the result was held");
`endif

endmodule

// ----- rtl/shortest_arc_quaternion.sv -----
`timescale 1ns / 1ps

// Shortest-arc rotation: takes a start and a destination vector (signed 16-bit, any scale)
// and returns the unit quaternion that turns one onto the other, in signed fixed point with
// OUT_FRAC_BITS fraction bits, plus a status (normal, opposite-vector fallback, zero-length
// input). One vector pair is taken per clock while o_stall is low, and one result leaves per
// clock while i_stall is low. The delay from acceptance to result valid is set by the three
// pipelined square-root units (one root bit per stage) and the restoring dividers (one
// quotient bit per stage) for the normalization and for the axis; the default output is Q1.14.
// The front registers each pair and tests for zero length; a four-entry request queue
// lets it keep taking input while the back pipeline is held by a stalled output.
module shortest_arc_quaternion #(
    parameter int OUT_FRAC_BITS = sap_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_from_x,
    input  logic signed [15:0] i_from_y,
    input  logic signed [15:0] i_from_z,
    input  logic signed [15:0] i_to_x,
    input  logic signed [15:0] i_to_y,
    input  logic signed [15:0] i_to_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic [1:0]         o_status
);

    logic          push;
    logic          q_full;
    logic          q_avail;
    logic          pop;
    sap_pkg::t_req f_req;
    sap_pkg::t_req b_req;

    sap_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_from_z (i_from_z),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .i_to_z   (i_to_z),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (f_req)
    );

    sap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_req   (b_req)
    );

    sap_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (q_avail),
        .i_req    (b_req),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_status (o_status)
    );

endmodule

// ----- tb/shortest_arc_quaternion_tb.sv -----
`timescale 1ns / 1ps

module shortest_arc_quaternion_tb;

    localparam int FRAC = sap_pkg::OUT_FRAC_BITS_DEF;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint OPP_MARGIN = 1073742;
    localparam int LATENCY = 118;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        sap_pkg::t_status   st;
    } t_arc;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_from_x, i_from_y, i_from_z;
    logic signed [15:0] i_to_x, i_to_y, i_to_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic [1:0]         o_status;

    t_arc   arc_fifo[$];
    int     n_errors;
    int     n_sent;
    int     n_checked;
    int     n_status[3];
    int     cycle_cnt;
    int     hold_left;
    int     hold_req;
    bit     quiet_out;
    bit     quiet_in;

    shortest_arc_quaternion dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_from_z (i_from_z),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .i_to_z   (i_to_z),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_status (o_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round half away from zero
    function automatic longint round_div(longint n, longint unsigned d);
        longint unsigned m;
        longint unsigned q;
        if (d == 0) return 0;
        m = (n < 0) ? longint'(-n) : longint'(n);
        q = (m + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] sat_q(longint v);
        longint lim;
        lim = 64'sd1 << FRAC;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic bit to_unit(input longint v[3], output longint u[3]);
        longint unsigned l2;
        longint unsigned len;
        l2 = 0;
        for (int i = 0; i < 3; i++) l2 += longint'(v[i] * v[i]);
        u = '{0, 0, 0};
        if (l2 == 0) return 0;
        len = isqrt(l2 << 32);
        for (int i = 0; i < 3; i++) u[i] = round_div(v[i] * (64'sd1 << 46), len);
        return 1;
    endfunction

    function automatic t_arc predict_arc(logic signed [15:0] fv[6]);
        t_arc   r;
        longint a[3], b[3], ua[3], ub[3], q[4], e[3], c[3];
        longint d, s, v;
        longint unsigned xy, l2, len;
        bit     oka, okb;
        for (int i = 0; i < 3; i++) begin
            a[i] = fv[i];
            b[i] = fv[i + 3];
        end
        q = '{0, 0, 0, 0};
        oka = to_unit(a, ua);
        okb = to_unit(b, ub);
        if (!oka || !okb) begin
            r.st = sap_pkg::ST_ZERO;
        end else begin
            d = round_div(ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2], ONE_Q30);
            if (d < -(ONE_Q30 - OPP_MARGIN)) begin
                xy = longint'(ua[0] * ua[0]) + longint'(ua[1] * ua[1]);
                if (xy < sap_pkg::SMALL_AXIS) e = '{0, -ua[2], ua[1]};
                else e = '{-ua[1], ua[0], 0};
                l2 = longint'(e[0] * e[0]) + longint'(e[1] * e[1]) + longint'(e[2] * e[2]);
                len = isqrt(l2);
                for (int i = 0; i < 3; i++) q[i + 1] = round_div(e[i] * (64'sd1 << FRAC), len);
                r.st = sap_pkg::ST_OPPOSITE;
            end else begin
                c[0] = round_div(ua[1] * ub[2] - ua[2] * ub[1], ONE_Q30);
                c[1] = round_div(ua[2] * ub[0] - ua[0] * ub[2], ONE_Q30);
                c[2] = round_div(ua[0] * ub[1] - ua[1] * ub[0], ONE_Q30);
                v = 2 * (ONE_Q30 + d);
                if (v < 0) v = 0;
                s = longint'(isqrt(longint'(v) << 30));
                q[0] = round_div(s, 64'd1 << (31 - FRAC));
                for (int i = 0; i < 3; i++) q[i + 1] = round_div(c[i] * (64'sd1 << FRAC), s);
                r.st = sap_pkg::ST_NORMAL;
            end
        end
        r.w = sat_q(q[0]);
        r.x = sat_q(q[1]);
        r.y = sat_q(q[2]);
        r.z = sat_q(q[3]);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pair(logic signed [15:0] fv[6]);
        int gap;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_from_x <= fv[0];
        i_from_y <= fv[1];
        i_from_z <= fv[2];
        i_to_x   <= fv[3];
        i_to_y   <= fv[4];
        i_to_z   <= fv[5];
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        arc_fifo.push_back(predict_arc(fv));
        n_sent++;
    endtask

    task automatic send6(int fx, int fy, int fz, int tx, int ty, int tz);
        logic signed [15:0] fv[6];
        fv = '{fx[15:0], fy[15:0], fz[15:0], tx[15:0], ty[15:0], tz[15:0]};
        send_pair(fv);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (arc_fifo.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_arc ex;
        if (i_rst_n && o_valid && !i_stall) begin
            if (arc_fifo.size() == 0) begin
                $display("%0t: result with no request pending (w=%0d x=%0d y=%0d z=%0d st=%0d)",
                         $time, o_quat_w, o_quat_x, o_quat_y, o_quat_z, o_status);
                n_errors++;
            end else begin
                ex = arc_fifo.pop_front();
                n_checked++;
                n_status[ex.st]++;
                if (o_quat_w !== ex.w) begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, ex.w, o_quat_w);
                    n_errors++;
                end
                if (o_quat_x !== ex.x) begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, ex.x, o_quat_x);
                    n_errors++;
                end
                if (o_quat_y !== ex.y) begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, ex.y, o_quat_y);
                    n_errors++;
                end
                if (o_quat_z !== ex.z) begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, ex.z, o_quat_z);
                    n_errors++;
                end
                if (o_status !== ex.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, ex.st, o_status);
                    n_errors++;
                end
            end
        end
    end

    // receiver stall, with long holds counted down here
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left <= hold_req - 1;
            hold_req = 0;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (quiet_out) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 20);
            if ($urandom_range(0, 199) == 0) hold_left <= $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("shortest_arc_quaternion: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send6(32767, 32767, 32767, 32767, 32767, 32767);
        send6(-32768, -32768, -32768, -32768, -32768, -32768);
        send6(-32768, 0, 0, 32767, 0, 0);
        send6(0, 0, 0, 1, 2, 3);
        send6(5, -7, 9, 0, 0, 0);
        send6(0, 0, 0, 0, 0, 0);
        send6(1, 0, 0, -1, 0, 0);
        send6(0, 0, 1, 0, 0, -1);
        send6(0, 1, 0, 0, -1, 0);
        send6(0, 3, 1000, 0, -3, -1000);
        send6(1000, 1000, 1000, -1000, -999, -1001);
        send6(1, 0, 0, 0, 1, 0);
        send6(0, 1, 0, 0, 0, 1);
        send6(1, 1, 1, 2, 2, 2);
        send6(32767, -32768, 1, -1, 32767, -32768);
        send6(-32768, 32767, -32768, 32767, -32768, 32767);
        send6(100, 0, 0, -100, 40, 0);
        send6(1, 0, 0, 0, 0, 0);
        send6(-1, -1, -1, 1, 1, 1);
        send6(16384, 0, 0, 0, 0, -16384);
        wait_drained();
    endtask

    task automatic test_random_wide(int n);
        logic signed [15:0] fv[6];
        int base;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 6; i++) fv[i] = 16'($urandom);
            if ($urandom_range(0, 19) == 0) begin
                base = 3 * int'($urandom_range(0, 1));
                for (int i = 0; i < 3; i++) fv[base + i] = '0;
            end
            send_pair(fv);
        end
    endtask

    task automatic test_random_short(int n);
        logic signed [15:0] fv[6];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 6; i++) fv[i] = 16'(int'($urandom_range(0, 8)) - 4);
            send_pair(fv);
        end
    endtask

    // destination close to the negated start vector
    task automatic test_near_opposite(int n);
        logic signed [15:0] fv[6];
        int m;
        for (int k = 0; k < n; k++) begin
            m = (k % 3 == 0) ? 16000 : 200;
            for (int i = 0; i < 3; i++) fv[i] = 16'(int'($urandom_range(0, 2 * m)) - m);
            if (k % 4 == 0) begin
                fv[0] = 16'(int'($urandom_range(0, 20)) - 10);
                fv[1] = 16'(int'($urandom_range(0, 20)) - 10);
            end
            for (int i = 0; i < 3; i++)
                fv[i + 3] = 16'(-fv[i] + int'($urandom_range(0, 6)) - 3);
            send_pair(fv);
        end
    endtask

    // hold the output long enough for the pipeline and queue to fill
    task automatic test_backpressure();
        hold_req = 400;
        quiet_in = 1;
        test_random_wide(160);
        quiet_in = 0;
        wait_drained();
    endtask

    task automatic test_no_idle();
        quiet_in = 1;
        quiet_out = 1;
        test_random_wide(60);
        quiet_in = 0;
        quiet_out = 0;
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_from_x = '0;
        i_from_y = '0;
        i_from_z = '0;
        i_to_x = '0;
        i_to_y = '0;
        i_to_z = '0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_status = '{0, 0, 0};
        cycle_cnt = 0;
        hold_left = 0;
        hold_req = 0;
        quiet_out = 0;
        quiet_in = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_wide(230);
        test_backpressure();
        test_random_short(100);
        test_near_opposite(150);
        test_no_idle();
        test_random_wide(50);

        wait_drained();
        repeat (LATENCY + 50) @(posedge i_clk);
        $display("sent %0d vector pairs, checked %0d results", n_sent, n_checked);
        $display("normal %0d, opposite fallback %0d, zero length %0d",
                 n_status[0], n_status[1], n_status[2]);
        if (n_errors == 0 && arc_fifo.size() == 0) begin
            $display("shortest_arc_quaternion: match");
        end else begin
            $display("shortest_arc_quaternion: mismatch");
        end
        $finish;
    end

endmodule
